/* design/rmh_pkg.sv */
// ----------------------------------------------------------------------------
// rmh_pkg: shared constants and types for the running median core
// Holds the sample and heap geometry and the command and status bundles
// that pass between the sequencer and the heap engines.
// ----------------------------------------------------------------------------
package rmh_pkg;
    localparam int SAMPLE_W   = 32;
    localparam int MEDIAN_W   = SAMPLE_W + 1;
    localparam int HEAP_DEPTH = 512;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int SIZE_W     = ADDR_W + 1;
    localparam int COUNT_W    = 10;
    localparam int CAPACITY   = 2 * HEAP_DEPTH - 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic    push;
        logic    pop;
        sample_t value;
    } heap_cmd_t;

    typedef struct packed {
        logic              busy;
        logic [SIZE_W-1:0] size;
        sample_t           top;
    } heap_stat_t;
endpackage

/* design/rmh_heap.sv */
// ----------------------------------------------------------------------------
// rmh_heap: binary heap engine with one read port and one write port on its memory
// Performs push (sift up) and pop (sift down) one level at a time with
// comparisons ordered by is_max; keeps the root in a register.
// ----------------------------------------------------------------------------
module rmh_heap import rmh_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       is_max,
    input  heap_cmd_t  cmd,
    output heap_stat_t stat
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PUCHK = 3'd1;
    localparam logic [2:0] ST_PUCMP = 3'd2;
    localparam logic [2:0] ST_POLST = 3'd3;
    localparam logic [2:0] ST_POCHK = 3'd4;
    localparam logic [2:0] ST_POC1  = 3'd5;
    localparam logic [2:0] ST_POCMP = 3'd6;

    sample_t mem [HEAP_DEPTH];

    logic [2:0]        state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    sample_t           val_reg, val_next;
    sample_t           cval_reg, cval_next;
    sample_t           top_reg, top_next;
    sample_t           rd_q;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic              wr_en;
    sample_t           wr_data;

    logic [SIZE_W:0]   child;
    logic [SIZE_W:0]   child1;
    logic [ADDR_W-1:0] parent;
    logic              sel1;
    sample_t           best;
    logic [ADDR_W-1:0] best_idx;

    // True when a belongs above b in this heap's ordering.
    function automatic logic above(input sample_t a, input sample_t b, input logic mx);
        above = mx ? (a > b) : (a < b);
    endfunction

    assign child    = {idx_reg, 1'b1} & {(SIZE_W+1){1'b1}};
    assign child1   = child + 1'b1;
    assign parent   = ADDR_W'((idx_reg - 1'b1) >> 1);
    assign sel1     = (child1 < {1'b0, size_reg}) && above(rd_q, cval_reg, is_max);
    assign best     = sel1 ? rd_q : cval_reg;
    assign best_idx = sel1 ? child1[ADDR_W-1:0] : child[ADDR_W-1:0];

    always_comb begin
        state_next = state_reg;
        size_next  = size_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        cval_next  = cval_reg;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = val_reg;
        unique case (state_reg)
            ST_IDLE: begin
                rd_addr = ADDR_W'(size_reg - 1'b1);
                if (cmd.push) begin
                    val_next   = cmd.value;
                    idx_next   = size_reg[ADDR_W-1:0];
                    size_next  = size_reg + 1'b1;
                    state_next = ST_PUCHK;
                end else if (cmd.pop) begin
                    size_next = size_reg - 1'b1;
                    idx_next  = '0;
                    if (size_reg > SIZE_W'(1)) begin
                        state_next = ST_POLST;
                    end
                end
            end
            ST_PUCHK: begin
                rd_addr = parent;
                if (idx_reg == '0) begin
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_PUCMP;
                end
            end
            ST_PUCMP: begin
                wr_en = 1'b1;
                if (above(val_reg, rd_q, is_max)) begin
                    wr_data    = rd_q;
                    idx_next   = parent;
                    state_next = ST_PUCHK;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_POLST: begin
                val_next   = rd_q;
                state_next = ST_POCHK;
            end
            ST_POCHK: begin
                rd_addr = child[ADDR_W-1:0];
                if (child >= {1'b0, size_reg}) begin
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_POC1;
                end
            end
            ST_POC1: begin
                rd_addr    = child1[ADDR_W-1:0];
                cval_next  = rd_q;
                state_next = ST_POCMP;
            end
            ST_POCMP: begin
                wr_en = 1'b1;
                if (above(best, val_reg, is_max)) begin
                    wr_data    = best;
                    idx_next   = best_idx;
                    state_next = ST_POCHK;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        top_next = (wr_en && wr_addr == '0) ? wr_data : top_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            size_reg  <= '0;
        end else begin
            state_reg <= state_next;
            size_reg  <= size_next;
        end
        idx_reg  <= idx_next;
        val_reg  <= val_next;
        cval_reg <= cval_next;
        top_reg  <= top_next;
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.size = size_reg;
    assign stat.top  = top_reg;
endmodule

/* design/running_median_two_heaps_core.sv */
// ----------------------------------------------------------------------------
// running_median_two_heaps_core: streaming median over all stored samples
// Two heap engines (max-heap of the lower half, min-heap of the upper half)
// under a small sequencer; reports twice the median after every sample.
// ----------------------------------------------------------------------------
// Each accepted sample is pushed into one heap, and if the sizes then differ
// by two, the larger heap's root is popped while the same value is pushed
// into the other heap; the two engines run that move in parallel. A push
// visits a check and a compare state per heap level, and a pop a check, a
// second-child read and a compare state, because each engine owns one memory
// with one read port and a registered read. The input is not ready while a
// sample is in work. The result sits in an output register, so the next
// sample may be accepted while the previous result still waits. Heap
// memories hold no reset value; only entries below each heap's size are
// used. When 2*depth-2 samples are held, a further sample is dropped with
// dropped set and the median unchanged.
module running_median_two_heaps_core import rmh_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [MEDIAN_W-1:0] m_median_x2,
    output logic [COUNT_W-1:0]         m_stored_count,
    output logic                       m_dropped
);
    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_INS  = 2'd1;
    localparam logic [1:0] T_BAL  = 2'd2;
    localparam logic [1:0] T_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       drop_reg, drop_next;
    logic       m_valid_reg, m_valid_next;
    logic signed [MEDIAN_W-1:0] med_reg, med_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic       drop_out_reg, drop_out_next;

    heap_cmd_t  lo_cmd, hi_cmd;
    heap_stat_t lo_stat, hi_stat;
    logic [SIZE_W:0] total;
    logic signed [MEDIAN_W-1:0] lo_ext, hi_ext;
    logic       out_free;

    rmh_heap u_lower (
        .aclk    (aclk),
        .aresetn (aresetn),
        .is_max  (1'b1),
        .cmd     (lo_cmd),
        .stat    (lo_stat)
    );

    rmh_heap u_upper (
        .aclk    (aclk),
        .aresetn (aresetn),
        .is_max  (1'b0),
        .cmd     (hi_cmd),
        .stat    (hi_stat)
    );

    assign total    = {1'b0, lo_stat.size} + {1'b0, hi_stat.size};
    assign lo_ext   = MEDIAN_W'(lo_stat.top);
    assign hi_ext   = MEDIAN_W'(hi_stat.top);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == T_IDLE);

    always_comb begin
        state_next    = state_reg;
        drop_next     = drop_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        med_next      = med_reg;
        cnt_next      = cnt_reg;
        drop_out_next = drop_out_reg;
        lo_cmd        = '{push: 1'b0, pop: 1'b0, value: s_sample};
        hi_cmd        = '{push: 1'b0, pop: 1'b0, value: s_sample};
        unique case (state_reg)
            T_IDLE: begin
                if (s_valid) begin
                    if (total >= (SIZE_W+1)'(CAPACITY)) begin
                        // Full: leave the heaps alone and report as is.
                        drop_next  = 1'b1;
                        state_next = T_OUT;
                    end else begin
                        drop_next  = 1'b0;
                        state_next = T_INS;
                        // Ties with the lower root go to the upper heap.
                        if (lo_stat.size == '0 || lo_stat.top > s_sample) begin
                            lo_cmd.push = 1'b1;
                        end else begin
                            hi_cmd.push = 1'b1;
                        end
                    end
                end
            end
            T_INS: begin
                if (!lo_stat.busy && !hi_stat.busy) begin
                    state_next = T_BAL;
                    // Move one root across when the sizes differ by two.
                    if (lo_stat.size > hi_stat.size + 1'b1) begin
                        lo_cmd.pop   = 1'b1;
                        hi_cmd.push  = 1'b1;
                        hi_cmd.value = lo_stat.top;
                    end else if (hi_stat.size > lo_stat.size + 1'b1) begin
                        hi_cmd.pop   = 1'b1;
                        lo_cmd.push  = 1'b1;
                        lo_cmd.value = hi_stat.top;
                    end
                end
            end
            T_BAL: begin
                if (!lo_stat.busy && !hi_stat.busy) begin
                    state_next = T_OUT;
                end
            end
            T_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    cnt_next      = COUNT_W'(total);
                    drop_out_next = drop_reg;
                    priority if (lo_stat.size == '0 && hi_stat.size == '0) begin
                        med_next = '0;
                    end else if (lo_stat.size == hi_stat.size) begin
                        med_next = lo_ext + hi_ext;
                    end else if (lo_stat.size > hi_stat.size) begin
                        med_next = lo_ext + lo_ext;
                    end else begin
                        med_next = hi_ext + hi_ext;
                    end
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        drop_reg     <= drop_next;
        med_reg      <= med_next;
        cnt_reg      <= cnt_next;
        drop_out_reg <= drop_out_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_median_x2    = med_reg;
    assign m_stored_count = cnt_reg;
    assign m_dropped      = drop_out_reg;
endmodule
